// File: rtl/core/gts_pkg.sv
// Shared types, constants and helpers for the grammar token scanner.
// Used by gts_front, gts_back, gts_outq and grammar_token_scanner.
// Depends on nothing.
`default_nettype none
package gts_pkg;

	localparam int OFFSET_BITS = 24;
	localparam int COUNT_BITS  = 16;

	// depth of both internal queues; a power of two
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// byte codes the scanner reacts to
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_QMARK  = 8'h3F;

	typedef enum logic [4:0] {
		TK_EOF      = 5'd0,
		TK_IDENT    = 5'd1,
		TK_STRING   = 5'd2,
		TK_NUMBER   = 5'd3,
		TK_ARROW    = 5'd4,
		TK_PIPE     = 5'd5,
		TK_SEMI     = 5'd6,
		TK_LPAREN   = 5'd7,
		TK_RPAREN   = 5'd8,
		TK_LBRACE   = 5'd9,
		TK_RBRACE   = 5'd10,
		TK_COLON    = 5'd11,
		TK_EQUALS   = 5'd12,
		TK_PLUS     = 5'd13,
		TK_STAR     = 5'd14,
		TK_QUESTION = 5'd15,
		TK_NEWLINE  = 5'd16,
		TK_ERROR    = 5'd17
	} tok_kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_IDENT  = 3'd1,
		MODE_NUMBER = 3'd2,
		MODE_STRING = 3'd3,
		MODE_ESCAPE = 3'd4,
		MODE_DASH   = 3'd5
	} scan_mode_t;

	// byte class worked out by the front end
	typedef enum logic [3:0] {
		CL_WS     = 4'd0,
		CL_NL     = 4'd1,
		CL_DASH   = 4'd2,
		CL_QUOTE  = 4'd3,
		CL_PUNCT  = 4'd4,
		CL_ALPHA  = 4'd5,
		CL_DIGIT  = 4'd6,
		CL_GT     = 4'd7,
		CL_BSLASH = 4'd8,
		CL_OTHER  = 4'd9,
		CL_EOI    = 4'd10
	} byte_class_t;

	// classified item; tk is the single-byte token kind (error unless punctuation)
	typedef struct packed {
		byte_class_t cls;
		tok_kind_t   tk;
	} item_t;

	typedef struct packed {
		tok_kind_t               kind;
		logic [COUNT_BITS-1:0]   line;
		logic [COUNT_BITS-1:0]   column;
		logic [OFFSET_BITS-1:0]  offset;
		logic [COUNT_BITS-1:0]   length;
		logic                    last;
	} token_t;

	// write side of the token queue: zero, one or two tokens a cycle
	typedef struct packed {
		logic   one;
		logic   two;
		token_t d0;
		token_t d1;
	} tq_wr_t;

	function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] v);
		cnt_inc = (v == {COUNT_BITS{1'b1}}) ? v : COUNT_BITS'(v + 1'b1);
	endfunction

	function automatic logic [OFFSET_BITS-1:0] off_inc(input logic [OFFSET_BITS-1:0] v);
		off_inc = (v == {OFFSET_BITS{1'b1}}) ? v : OFFSET_BITS'(v + 1'b1);
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/gts_front.sv
// Front end of the grammar token scanner: classifies each incoming byte
// and holds classified items in a short queue for the back end.
// Depends on gts_pkg.
`default_nettype none
module gts_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire logic            kind,
	input  wire logic [7:0]      char_byte,
	output logic                 item_valid,
	output gts_pkg::item_t       item,
	input  wire logic            item_pop
);

	gts_pkg::item_t                  cls_item;
	gts_pkg::item_t                  mem_q [gts_pkg::QDEPTH];
	logic [gts_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [gts_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [gts_pkg::QPTR_W:0]        cnt_q;
	logic                            wr_en;
	logic                            rd_en;

	// classify the byte
	always_comb begin
		cls_item.tk  = gts_pkg::TK_ERROR;
		cls_item.cls = gts_pkg::CL_OTHER;
		if (kind) begin
			cls_item.cls = gts_pkg::CL_EOI;
		end else begin
			case (char_byte) inside
				gts_pkg::CH_SPACE, gts_pkg::CH_TAB, gts_pkg::CH_CR: cls_item.cls = gts_pkg::CL_WS;
				gts_pkg::CH_NL:     cls_item.cls = gts_pkg::CL_NL;
				gts_pkg::CH_DASH:   cls_item.cls = gts_pkg::CL_DASH;
				gts_pkg::CH_QUOTE:  cls_item.cls = gts_pkg::CL_QUOTE;
				gts_pkg::CH_GT:     cls_item.cls = gts_pkg::CL_GT;
				gts_pkg::CH_BSLASH: cls_item.cls = gts_pkg::CL_BSLASH;
				[8'h41:8'h5A], [8'h61:8'h7A], gts_pkg::CH_UNDER: begin
					cls_item.cls = gts_pkg::CL_ALPHA;
				end
				[8'h30:8'h39]: cls_item.cls = gts_pkg::CL_DIGIT;
				gts_pkg::CH_PIPE: begin
					cls_item.cls = gts_pkg::CL_PUNCT;
					cls_item.tk  = gts_pkg::TK_PIPE;
				end
				gts_pkg::CH_SEMI: begin
					cls_item.cls = gts_pkg::CL_PUNCT;
					cls_item.tk  = gts_pkg::TK_SEMI;
				end
				gts_pkg::CH_LPAREN: begin
					cls_item.cls = gts_pkg::CL_PUNCT;
					cls_item.tk  = gts_pkg::TK_LPAREN;
				end
				gts_pkg::CH_RPAREN: begin
					cls_item.cls = gts_pkg::CL_PUNCT;
					cls_item.tk  = gts_pkg::TK_RPAREN;
				end
				gts_pkg::CH_LBRACE: begin
					cls_item.cls = gts_pkg::CL_PUNCT;
					cls_item.tk  = gts_pkg::TK_LBRACE;
				end
				gts_pkg::CH_RBRACE: begin
					cls_item.cls = gts_pkg::CL_PUNCT;
					cls_item.tk  = gts_pkg::TK_RBRACE;
				end
				gts_pkg::CH_COLON: begin
					cls_item.cls = gts_pkg::CL_PUNCT;
					cls_item.tk  = gts_pkg::TK_COLON;
				end
				gts_pkg::CH_EQUALS: begin
					cls_item.cls = gts_pkg::CL_PUNCT;
					cls_item.tk  = gts_pkg::TK_EQUALS;
				end
				gts_pkg::CH_PLUS: begin
					cls_item.cls = gts_pkg::CL_PUNCT;
					cls_item.tk  = gts_pkg::TK_PLUS;
				end
				gts_pkg::CH_STAR: begin
					cls_item.cls = gts_pkg::CL_PUNCT;
					cls_item.tk  = gts_pkg::TK_STAR;
				end
				gts_pkg::CH_QMARK: begin
					cls_item.cls = gts_pkg::CL_PUNCT;
					cls_item.tk  = gts_pkg::TK_QUESTION;
				end
				default: cls_item.cls = gts_pkg::CL_OTHER;
			endcase
		end
	end

	assign full       = (cnt_q == (gts_pkg::QPTR_W+1)'(gts_pkg::QDEPTH));
	assign item_valid = (cnt_q != '0);
	assign item       = mem_q[rd_ptr_q];
	assign wr_en      = push && !full;
	assign rd_en      = item_pop && item_valid;

	// store the classified beat
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= cls_item;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= gts_pkg::QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (rd_en) begin
				rd_ptr_q <= gts_pkg::QPTR_W'(rd_ptr_q + 1'b1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= (gts_pkg::QPTR_W+1)'(cnt_q + 1'b1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= (gts_pkg::QPTR_W+1)'(cnt_q - 1'b1);
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (gts_pkg::QPTR_W+1)'(gts_pkg::QDEPTH))
		else $error("item queue overfilled");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		gts_pkg::QPTR_W'(wr_ptr_q - rd_ptr_q) == cnt_q[gts_pkg::QPTR_W-1:0])
		else $error("item queue pointers disagree with fill count");
	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && !wr_en) |=> cnt_q == (gts_pkg::QPTR_W+1)'($past(cnt_q) - 1'b1))
		else $error("item queue pop lost");

endmodule
`default_nettype wire

// File: rtl/core/gts_outq.sv
// Token queue of the grammar token scanner: takes up to two tokens a cycle
// from the back end and hands out one a cycle on the result side while popped.
// Depends on gts_pkg.
`default_nettype none
module gts_outq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  gts_pkg::tq_wr_t      wr,
	output logic                 room_two,
	output logic                 empty,
	input  wire logic            pop,
	output gts_pkg::token_t      head
);

	gts_pkg::token_t                 mem_q [gts_pkg::QDEPTH];
	logic [gts_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [gts_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [gts_pkg::QPTR_W:0]        cnt_q;
	logic [gts_pkg::QPTR_W-1:0]      wr_ptr_nx;
	logic [1:0]                      n_push;
	logic                            rd_en;

	assign empty     = (cnt_q == '0);
	assign room_two  = (cnt_q <= (gts_pkg::QPTR_W+1)'(gts_pkg::QDEPTH - 2));
	assign head      = mem_q[rd_ptr_q];
	assign rd_en     = pop && !empty;
	assign wr_ptr_nx = gts_pkg::QPTR_W'(wr_ptr_q + 1'b1);
	assign n_push    = wr.two ? 2'd2 : (wr.one ? 2'd1 : 2'd0);

	// write the beats in order
	always_ff @(posedge clk) begin
		if (wr.one) begin
			mem_q[wr_ptr_q] <= wr.d0;
		end
		if (wr.two) begin
			mem_q[wr_ptr_nx] <= wr.d1;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= gts_pkg::QPTR_W'(wr_ptr_q + n_push);
			if (rd_en) begin
				rd_ptr_q <= gts_pkg::QPTR_W'(rd_ptr_q + 1'b1);
			end
			cnt_q <= (gts_pkg::QPTR_W+1)'(cnt_q + n_push - {1'b0, rd_en});
		end
	end

	a_two_implies_one: assert property (@(posedge clk) disable iff (!arst_n)
		wr.two |-> wr.one)
		else $error("second token written without first");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (gts_pkg::QPTR_W+1)'(gts_pkg::QDEPTH))
		else $error("token queue overfilled");
	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.two && !rd_en) |=> cnt_q == (gts_pkg::QPTR_W+1)'($past(cnt_q) + 2'd2))
		else $error("token queue lost a beat of a pair");

endmodule
`default_nettype wire

// File: rtl/core/gts_back.sv
// Back end of the grammar token scanner: holds the scan mode and the
// position counters and turns each classified item into zero to two tokens.
// Depends on gts_pkg.
`default_nettype none
module gts_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	input  gts_pkg::item_t       item,
	output logic                 item_pop,
	input  wire logic            room_two,
	output gts_pkg::tq_wr_t      wr
);

	gts_pkg::scan_mode_t                  mode_q, mode_d;
	logic [gts_pkg::COUNT_BITS-1:0]       line_q, line_d;
	logic [gts_pkg::COUNT_BITS-1:0]       col_q, col_d;
	logic [gts_pkg::OFFSET_BITS-1:0]      off_q, off_d;
	logic [gts_pkg::COUNT_BITS-1:0]       tline_q, tline_d;
	logic [gts_pkg::COUNT_BITS-1:0]       tcol_q, tcol_d;
	logic [gts_pkg::OFFSET_BITS-1:0]      toff_q, toff_d;
	logic [gts_pkg::COUNT_BITS-1:0]       tlen_q, tlen_d;

	logic                                 fresh;
	logic                                 p_valid;
	gts_pkg::tok_kind_t                   p_kind;
	logic [gts_pkg::COUNT_BITS-1:0]       p_len;
	logic                                 h_valid;
	gts_pkg::tok_kind_t                   h_kind;
	gts_pkg::token_t                      p_tok;
	gts_pkg::token_t                      h_tok;
	logic                                 cont;

	assign item_pop = item_valid && room_two;

	// scan one item against the mode and counters
	always_comb begin
		mode_d  = mode_q;
		line_d  = line_q;
		col_d   = col_q;
		off_d   = off_q;
		tline_d = tline_q;
		tcol_d  = tcol_q;
		toff_d  = toff_q;
		tlen_d  = tlen_q;
		fresh   = 1'b0;
		p_valid = 1'b0;
		p_kind  = gts_pkg::TK_ERROR;
		p_len   = '0;
		h_valid = 1'b0;
		h_kind  = gts_pkg::TK_ERROR;
		cont    = 1'b0;

		if (item.cls == gts_pkg::CL_EOI) begin
			// close any pending token, emit eof and return to reset values
			case (mode_q)
				gts_pkg::MODE_IDENT: begin
					p_valid = 1'b1;
					p_kind  = gts_pkg::TK_IDENT;
					p_len   = tlen_q;
				end
				gts_pkg::MODE_NUMBER: begin
					p_valid = 1'b1;
					p_kind  = gts_pkg::TK_NUMBER;
					p_len   = tlen_q;
				end
				gts_pkg::MODE_STRING, gts_pkg::MODE_ESCAPE: begin
					p_valid = 1'b1;
					p_kind  = gts_pkg::TK_STRING;
					p_len   = tlen_q;
				end
				gts_pkg::MODE_DASH: begin
					p_valid = 1'b1;
					p_kind  = gts_pkg::TK_ERROR;
				end
				default: p_valid = 1'b0;
			endcase
			h_valid = 1'b1;
			h_kind  = gts_pkg::TK_EOF;
			mode_d  = gts_pkg::MODE_IDLE;
			line_d  = gts_pkg::COUNT_BITS'(1);
			col_d   = gts_pkg::COUNT_BITS'(1);
			off_d   = '0;
			tline_d = gts_pkg::COUNT_BITS'(1);
			tcol_d  = gts_pkg::COUNT_BITS'(1);
			toff_d  = '0;
			tlen_d  = '0;
		end else begin
			case (mode_q)
				gts_pkg::MODE_STRING: begin
					col_d = gts_pkg::cnt_inc(col_q);
					off_d = gts_pkg::off_inc(off_q);
					if (item.cls == gts_pkg::CL_QUOTE) begin
						p_valid = 1'b1;
						p_kind  = gts_pkg::TK_STRING;
						p_len   = tlen_q;
						mode_d  = gts_pkg::MODE_IDLE;
					end else begin
						tlen_d = gts_pkg::cnt_inc(tlen_q);
						if (item.cls == gts_pkg::CL_BSLASH) begin
							mode_d = gts_pkg::MODE_ESCAPE;
						end
					end
				end
				gts_pkg::MODE_ESCAPE: begin
					col_d  = gts_pkg::cnt_inc(col_q);
					off_d  = gts_pkg::off_inc(off_q);
					tlen_d = gts_pkg::cnt_inc(tlen_q);
					mode_d = gts_pkg::MODE_STRING;
				end
				gts_pkg::MODE_IDENT, gts_pkg::MODE_NUMBER: begin
					cont = (item.cls == gts_pkg::CL_DIGIT) ||
						(mode_q == gts_pkg::MODE_IDENT && item.cls == gts_pkg::CL_ALPHA);
					if (cont) begin
						tlen_d = gts_pkg::cnt_inc(tlen_q);
						col_d  = gts_pkg::cnt_inc(col_q);
						off_d  = gts_pkg::off_inc(off_q);
					end else begin
						p_valid = 1'b1;
						p_kind  = (mode_q == gts_pkg::MODE_IDENT) ?
							gts_pkg::TK_IDENT : gts_pkg::TK_NUMBER;
						p_len   = tlen_q;
						fresh   = 1'b1;
					end
				end
				gts_pkg::MODE_DASH: begin
					p_valid = 1'b1;
					if (item.cls == gts_pkg::CL_GT) begin
						p_kind = gts_pkg::TK_ARROW;
						col_d  = gts_pkg::cnt_inc(col_q);
						off_d  = gts_pkg::off_inc(off_q);
						mode_d = gts_pkg::MODE_IDLE;
					end else begin
						p_kind = gts_pkg::TK_ERROR;
						fresh  = 1'b1;
					end
				end
				default: fresh = 1'b1;
			endcase

			// scan the byte as the start of something new
			if (fresh) begin
				mode_d = gts_pkg::MODE_IDLE;
				col_d  = gts_pkg::cnt_inc(col_q);
				off_d  = gts_pkg::off_inc(off_q);
				case (item.cls)
					gts_pkg::CL_WS: mode_d = gts_pkg::MODE_IDLE;
					gts_pkg::CL_NL: begin
						h_valid = 1'b1;
						h_kind  = gts_pkg::TK_NEWLINE;
						line_d  = gts_pkg::cnt_inc(line_q);
						col_d   = gts_pkg::COUNT_BITS'(1);
					end
					gts_pkg::CL_DASH, gts_pkg::CL_QUOTE, gts_pkg::CL_ALPHA,
					gts_pkg::CL_DIGIT: begin
						tline_d = line_q;
						tcol_d  = col_q;
						toff_d  = off_q;
						tlen_d  = '0;
						case (item.cls)
							gts_pkg::CL_DASH: mode_d = gts_pkg::MODE_DASH;
							gts_pkg::CL_QUOTE: begin
								toff_d = gts_pkg::off_inc(off_q);
								mode_d = gts_pkg::MODE_STRING;
							end
							gts_pkg::CL_DIGIT: begin
								tlen_d = gts_pkg::COUNT_BITS'(1);
								mode_d = gts_pkg::MODE_NUMBER;
							end
							default: begin
								tlen_d = gts_pkg::COUNT_BITS'(1);
								mode_d = gts_pkg::MODE_IDENT;
							end
						endcase
					end
					default: begin
						h_valid = 1'b1;
						h_kind  = item.tk;
					end
				endcase
			end
		end
	end

	// build the pending token and the token at the current position
	always_comb begin
		p_tok.kind   = p_kind;
		p_tok.line   = tline_q;
		p_tok.column = tcol_q;
		p_tok.offset = toff_q;
		p_tok.length = p_len;
		p_tok.last   = !h_valid;
		h_tok.kind   = h_kind;
		h_tok.line   = line_q;
		h_tok.column = col_q;
		h_tok.offset = off_q;
		h_tok.length = '0;
		h_tok.last   = 1'b1;
		wr.one       = item_pop && (p_valid || h_valid);
		wr.two       = item_pop && p_valid && h_valid;
		wr.d0        = p_valid ? p_tok : h_tok;
		wr.d1        = h_tok;
	end

	// hold scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= gts_pkg::MODE_IDLE;
			line_q  <= gts_pkg::COUNT_BITS'(1);
			col_q   <= gts_pkg::COUNT_BITS'(1);
			off_q   <= '0;
			tline_q <= gts_pkg::COUNT_BITS'(1);
			tcol_q  <= gts_pkg::COUNT_BITS'(1);
			toff_q  <= '0;
			tlen_q  <= '0;
		end else if (item_pop) begin
			mode_q  <= mode_d;
			line_q  <= line_d;
			col_q   <= col_d;
			off_q   <= off_d;
			tline_q <= tline_d;
			tcol_q  <= tcol_d;
			toff_q  <= toff_d;
			tlen_q  <= tlen_d;
		end
	end

	a_eoi_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(item_pop && item.cls == gts_pkg::CL_EOI) |=>
			(mode_q == gts_pkg::MODE_IDLE && line_q == gts_pkg::COUNT_BITS'(1) &&
			 off_q == '0))
		else $error("end of input did not reset the scanner");
	a_eoi_emits_two_max: assert property (@(posedge clk) disable iff (!arst_n)
		(item_pop && item.cls == gts_pkg::CL_EOI) |-> wr.one)
		else $error("end of input emitted no eof");
	a_line_positive: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0 && col_q != '0)
		else $error("position counter fell to zero");
	a_quiet_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!item_pop |=> $stable(mode_q) && $stable(off_q))
		else $error("scanner state moved without an item");

endmodule
`default_nettype wire

// File: rtl/core/grammar_token_scanner.sv
// Top level of the grammar token scanner.
// Instantiates gts_front, gts_back and gts_outq; depends on gts_pkg.
//
// Feed one text byte per push (kind 0) or end of input (kind 1); tokens come
// out one per pop, oldest first, with last_of_run marking the final token of
// each input beat. A byte is accepted every cycle while full is low. The first
// token of a beat reaches the result ports through the item queue and the
// token queue: the beat is classified into the item queue at acceptance and
// scanned into the token queue when the back end takes it, which waits for
// room for two tokens. The scanner handles one beat per cycle while that room
// is there, and the result side hands out one token per cycle while pop is
// high, so beats that close a pending token and also emit one of their own
// (punctuation, newline or end of input) put two tokens into the token queue.
// Position counters and lengths saturate; end of input returns every counter to its reset value.
`default_nettype none
module grammar_token_scanner (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic                           kind,
	input  wire logic [7:0]                     char_byte,
	output logic                                empty,
	input  wire logic                           pop,
	output logic [4:0]                          token_kind,
	output logic [gts_pkg::COUNT_BITS-1:0]      start_line,
	output logic [gts_pkg::COUNT_BITS-1:0]      start_column,
	output logic [gts_pkg::OFFSET_BITS-1:0]     value_offset,
	output logic [gts_pkg::COUNT_BITS-1:0]      value_length,
	output logic                                last_of_run
);

	logic                  item_valid;
	gts_pkg::item_t        item;
	logic                  item_pop;
	logic                  room_two;
	gts_pkg::tq_wr_t       wr;
	gts_pkg::token_t       head;

	gts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.char_byte  (char_byte),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	gts_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.room_two   (room_two),
		.wr         (wr)
	);

	gts_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.room_two (room_two),
		.empty    (empty),
		.pop      (pop),
		.head     (head)
	);

	// present the oldest token
	assign token_kind   = head.kind;
	assign start_line   = head.line;
	assign start_column = head.column;
	assign value_offset = head.offset;
	assign value_length = head.length;
	assign last_of_run  = head.last;

endmodule
`default_nettype wire

// File: tb/gts_token_checker.sv
// Token checker for the grammar token scanner: follows both queue ports,
// predicts the tokens of every accepted beat and compares them in order.
// Depends on gts_pkg for the token kinds, scan modes and byte codes.
`timescale 1ns / 1ps
module gts_token_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        kind,
	input  logic [7:0]  char_byte,
	input  logic        empty,
	input  logic        pop,
	input  logic [4:0]  token_kind,
	input  logic [15:0] start_line,
	input  logic [15:0] start_column,
	input  logic [23:0] value_offset,
	input  logic [15:0] value_length,
	input  logic        last_of_run,
	output int          errors,
	output int          pending,
	output int          beats_in,
	output int          tokens_out,
	output logic [17:0] kinds_seen
);
	import gts_pkg::*;

	typedef logic [COUNT_BITS-1:0]  count_t;
	typedef logic [OFFSET_BITS-1:0] offset_t;

	// scanner state as the predictor sees it
	scan_mode_t mode;
	count_t     cur_line, cur_col, tok_line, tok_col, tok_len;
	offset_t    cur_off, tok_off;

	// tokens still owed by the block, oldest first
	token_t     owed_tokens[$];
	token_t     beat_tokens[0:1];
	int         beat_count;

	initial begin
		errors = 0;
		pending = 0;
		beats_in = 0;
		tokens_out = 0;
		kinds_seen = '0;
	end

	function automatic count_t count_up(input count_t v);
		return (&v) ? v : count_t'(v + 1);
	endfunction

	function automatic offset_t offset_up(input offset_t v);
		return (&v) ? v : offset_t'(v + 1);
	endfunction

	function automatic bit is_alpha(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic bit is_num(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// single-byte token kind; error for anything that is not punctuation
	function automatic tok_kind_t punct_kind(input logic [7:0] c);
		case (c)
			CH_PIPE:   return TK_PIPE;
			CH_SEMI:   return TK_SEMI;
			CH_LPAREN: return TK_LPAREN;
			CH_RPAREN: return TK_RPAREN;
			CH_LBRACE: return TK_LBRACE;
			CH_RBRACE: return TK_RBRACE;
			CH_COLON:  return TK_COLON;
			CH_EQUALS: return TK_EQUALS;
			CH_PLUS:   return TK_PLUS;
			CH_STAR:   return TK_STAR;
			CH_QMARK:  return TK_QUESTION;
			default:   return TK_ERROR;
		endcase
	endfunction

	task automatic clear_scan();
		mode = MODE_IDLE;
		cur_line = count_t'(1);
		cur_col = count_t'(1);
		cur_off = '0;
		tok_line = count_t'(1);
		tok_col = count_t'(1);
		tok_off = '0;
		tok_len = '0;
	endtask

	task automatic add_token(input tok_kind_t k, input count_t ln, input count_t col,
			input offset_t off, input count_t len);
		token_t t;
		t.kind = k;
		t.line = ln;
		t.column = col;
		t.offset = off;
		t.length = len;
		t.last = 1'b0;
		beat_tokens[beat_count] = t;
		beat_count++;
	endtask

	task automatic add_pending(input tok_kind_t k, input count_t len);
		add_token(k, tok_line, tok_col, tok_off, len);
	endtask

	task automatic add_here(input tok_kind_t k);
		add_token(k, cur_line, cur_col, cur_off, '0);
	endtask

	task automatic step_pos();
		cur_col = count_up(cur_col);
		cur_off = offset_up(cur_off);
	endtask

	task automatic open_token();
		tok_line = cur_line;
		tok_col = cur_col;
		tok_off = cur_off;
		tok_len = '0;
	endtask

	// byte seen with no token in progress
	task automatic scan_fresh(input logic [7:0] c);
		case (c)
			CH_SPACE, CH_TAB, CH_CR: step_pos();
			CH_NL: begin
				add_here(TK_NEWLINE);
				cur_line = count_up(cur_line);
				cur_col = count_t'(1);
				cur_off = offset_up(cur_off);
			end
			CH_DASH: begin
				open_token();
				mode = MODE_DASH;
				step_pos();
			end
			CH_QUOTE: begin
				open_token();
				tok_off = offset_up(cur_off);
				mode = MODE_STRING;
				step_pos();
			end
			default: begin
				if (is_alpha(c) || is_num(c) || c == CH_UNDER) begin
					open_token();
					tok_len = count_t'(1);
					mode = is_num(c) ? MODE_NUMBER : MODE_IDENT;
				end else begin
					add_here(punct_kind(c));
				end
				step_pos();
			end
		endcase
	endtask

	// work out the tokens of one accepted beat and queue them
	task automatic predict_beat(input logic is_end, input logic [7:0] c);
		beat_count = 0;
		if (is_end) begin
			case (mode)
				MODE_IDENT:  add_pending(TK_IDENT, tok_len);
				MODE_NUMBER: add_pending(TK_NUMBER, tok_len);
				MODE_STRING, MODE_ESCAPE: add_pending(TK_STRING, tok_len);
				MODE_DASH:   add_pending(TK_ERROR, '0);
				default: ;
			endcase
			add_here(TK_EOF);
			clear_scan();
		end else begin
			case (mode)
				MODE_STRING: begin
					step_pos();
					if (c == CH_QUOTE) begin
						add_pending(TK_STRING, tok_len);
						mode = MODE_IDLE;
					end else begin
						tok_len = count_up(tok_len);
						if (c == CH_BSLASH)
							mode = MODE_ESCAPE;
					end
				end
				MODE_ESCAPE: begin
					step_pos();
					tok_len = count_up(tok_len);
					mode = MODE_STRING;
				end
				MODE_IDENT, MODE_NUMBER: begin
					if (is_num(c) || (mode == MODE_IDENT && (is_alpha(c) || c == CH_UNDER))) begin
						tok_len = count_up(tok_len);
						step_pos();
					end else begin
						add_pending(mode == MODE_IDENT ? TK_IDENT : TK_NUMBER, tok_len);
						mode = MODE_IDLE;
						scan_fresh(c);
					end
				end
				MODE_DASH: begin
					mode = MODE_IDLE;
					if (c == CH_GT) begin
						step_pos();
						add_pending(TK_ARROW, '0);
					end else begin
						add_pending(TK_ERROR, '0);
						scan_fresh(c);
					end
				end
				default: begin
					mode = MODE_IDLE;
					scan_fresh(c);
				end
			endcase
		end
		// flag the final token of the beat
		if (beat_count > 0)
			beat_tokens[beat_count - 1].last = 1'b1;
		for (int i = 0; i < beat_count; i++)
			owed_tokens.push_back(beat_tokens[i]);
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t ns: %s mismatch: expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	// compare one popped token with the oldest owed one
	task automatic check_token();
		token_t want;
		tokens_out++;
		if (owed_tokens.size() == 0) begin
			errors++;
			$display("%0t ns: token kind %0d line %0d col %0d popped, expected none",
				$time, token_kind, start_line, start_column);
		end else begin
			want = owed_tokens.pop_front();
			kinds_seen[want.kind] = 1'b1;
			check_field("token_kind", 32'(want.kind), 32'(token_kind));
			check_field("start_line", 32'(want.line), 32'(start_line));
			check_field("start_column", 32'(want.column), 32'(start_column));
			check_field("value_offset", 32'(want.offset), 32'(value_offset));
			check_field("value_length", 32'(want.length), 32'(value_length));
			check_field("last_of_run", 32'(want.last), 32'(last_of_run));
		end
	endtask

	// pop side first: a beat accepted now cannot have a token out yet
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			owed_tokens.delete();
			pending <= 0;
		end else begin
			if (pop && !empty)
				check_token();
			if (push && !full) begin
				beats_in++;
				predict_beat(kind, char_byte);
			end
			pending <= owed_tokens.size();
		end
	end

endmodule

// File: tb/tb_grammar_token_scanner.sv
// Testbench top for grammar_token_scanner: drives byte and end-of-input beats,
// pops tokens with random stalls and gives the verdict.
// Depends on gts_pkg, the scanner RTL and gts_token_checker.
`timescale 1ns / 1ps
module tb_grammar_token_scanner;
	import gts_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_BEATS = 1600;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        kind = 1'b0;
	logic [7:0]  char_byte = '0;
	logic        pop = 1'b0;
	logic        full, empty, last_of_run;
	logic [4:0]  token_kind;
	logic [15:0] start_line, start_column, value_length;
	logic [23:0] value_offset;

	int          errors, pending, beats_in, tokens_out;
	logic [17:0] kinds_seen;
	int          sent = 0;
	int          quiet = 0;
	bit          src_idle = 1'b1;
	bit          snk_idle = 1'b1;

	grammar_token_scanner u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.kind         (kind),
		.char_byte    (char_byte),
		.empty        (empty),
		.pop          (pop),
		.token_kind   (token_kind),
		.start_line   (start_line),
		.start_column (start_column),
		.value_offset (value_offset),
		.value_length (value_length),
		.last_of_run  (last_of_run)
	);

	gts_token_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.kind         (kind),
		.char_byte    (char_byte),
		.empty        (empty),
		.pop          (pop),
		.token_kind   (token_kind),
		.start_line   (start_line),
		.start_column (start_column),
		.value_offset (value_offset),
		.value_length (value_length),
		.last_of_run  (last_of_run),
		.errors       (errors),
		.pending      (pending),
		.beats_in     (beats_in),
		.tokens_out   (tokens_out),
		.kinds_seen   (kinds_seen)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// pop side: random stall before each token, none while snk_idle is clear
	initial begin
		int unsigned stall;
		@(posedge arst_n);
		forever begin
			stall = snk_idle ? $urandom_range(0, 15) : 0;
			if (stall != 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	// end the run when no beat has moved on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet == QUIET_LIMIT) begin
				$display("%0t ns: no beat moved for %0d cycles", $time, QUIET_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// hold push high across back-to-back beats; drop it only for a gap
	task automatic send_beat(input logic is_end, input logic [7:0] b);
		int unsigned gap;
		gap = src_idle ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		kind <= is_end;
		char_byte <= b;
		do @(posedge clk); while (full);
		sent++;
	endtask

	task automatic send_char(input logic [7:0] b);
		send_beat(1'b0, b);
	endtask

	task automatic send_end();
		send_beat(1'b1, 8'($urandom));
	endtask

	// hold off the sender until every owed token has been popped
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_letter();
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] pick_digit();
		return 8'h30 + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] pick_word_char();
		case ($urandom_range(0, 2))
			0: return pick_letter();
			1: return pick_digit();
			default: return CH_UNDER;
		endcase
	endfunction

	function automatic logic [7:0] pick_punct();
		case ($urandom_range(0, 10))
			0: return CH_PIPE;
			1: return CH_SEMI;
			2: return CH_LPAREN;
			3: return CH_RPAREN;
			4: return CH_LBRACE;
			5: return CH_RBRACE;
			6: return CH_COLON;
			7: return CH_EQUALS;
			8: return CH_PLUS;
			9: return CH_STAR;
			default: return CH_QMARK;
		endcase
	endfunction

	function automatic logic [7:0] pick_space();
		case ($urandom_range(0, 2))
			0: return CH_SPACE;
			1: return CH_TAB;
			default: return CH_CR;
		endcase
	endfunction

	// one well-formed lexeme with random content, or noise now and then
	task automatic send_lexeme();
		int unsigned sel, n;
		logic [7:0] b;
		sel = $urandom_range(0, 99);
		if (sel < 20) begin
			send_char($urandom_range(0, 3) == 0 ? CH_UNDER : pick_letter());
			n = $urandom_range(0, 7);
			repeat (n) send_char(pick_word_char());
		end else if (sel < 32) begin
			n = $urandom_range(1, 6);
			repeat (n) send_char(pick_digit());
		end else if (sel < 44) begin
			send_char(CH_QUOTE);
			n = $urandom_range(0, 8);
			repeat (n) begin
				case ($urandom_range(0, 9))
					0: begin
						send_char(CH_BSLASH);
						send_char(8'($urandom));
					end
					1: send_char(CH_NL);
					default: begin
						b = 8'($urandom);
						send_char((b == CH_QUOTE || b == CH_BSLASH) ? 8'h78 : b);
					end
				endcase
			end
			// now and then leave the string open to the end of input
			if ($urandom_range(0, 9) == 0)
				send_end();
			else
				send_char(CH_QUOTE);
		end else if (sel < 50) begin
			send_char(CH_DASH);
			send_char(CH_GT);
		end else if (sel < 70) begin
			send_char(pick_punct());
		end else if (sel < 80) begin
			n = $urandom_range(1, 3);
			repeat (n) send_char(pick_space());
		end else if (sel < 87) begin
			send_char(CH_NL);
		end else if (sel < 91) begin
			send_char(CH_DASH);
		end else if (sel < 98) begin
			send_char(8'($urandom));
		end else begin
			send_end();
		end
	endtask

	initial begin
		string opening;
		int phase_end;
		opening = "_z9-0->\t\"\\\"\n\"\r";

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: identifier, number, arrow and string lexemes, escapes, lone dashes, extreme bytes
		for (int i = 0; i < opening.len(); i++)
			send_char(opening[i]);
		send_char(8'h80);
		send_char(8'hFF);
		send_char(CH_NL);
		send_char(CH_DASH);
		send_end();
		send_char(CH_QUOTE);
		send_char(CH_BSLASH);
		send_end();
		send_char(8'h00);
		send_end();
		send_end();
		drain();

		// random lexeme streams under changing idle patterns
		for (int p = 0; p < 8; p++) begin
			src_idle = (p == 0) ? 1'b1 : (p == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
			snk_idle = (p == 0) ? 1'b1 : (p == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
			phase_end = sent + RANDOM_BEATS / 8;
			while (sent < phase_end)
				send_lexeme();
			if (p % 3 == 2)
				drain();
		end
		drain();
		repeat (8) @(posedge clk);

		$display("Run covered %0d input beats and %0d checked tokens, %0d of 18 token kinds,",
			beats_in, tokens_out, $countones(kinds_seen));
		$display("random idling on both sides, full-rate streams and open strings at end.");
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
